>>> sv/bfre_pkg.sv
// ----------------------------------------------------------------------------
// bfre_pkg
// Shared types and constants of the box filter with region of interest and
// edge copy.
// ----------------------------------------------------------------------------
package bfre_pkg;

  localparam int KERNEL_MAX_DEF = 7;
  localparam int LINE_MAX_DEF   = 2048;

  localparam int PIX_W      = 8;
  localparam int CH_N       = 3;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 14;
  localparam int H_W        = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_X_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_X_LAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_FIRST   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_LAST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd7;

  localparam logic [2:0]       RST_KERNEL_SIZE  = 3'd3;
  localparam logic [COL_W-1:0] RST_FRAME_WIDTH  = 12'd2048;
  localparam logic [H_W-1:0]   RST_FRAME_HEIGHT = 13'd4096;
  localparam logic [COL_W-1:0] RST_ROI_FIRST    = 12'd0;
  localparam logic [COL_W-1:0] RST_ROI_LAST     = 12'd4095;
  localparam logic [1:0]       RST_CHAN_COUNT   = 2'd3;
  localparam logic [1:0]       CHAN_THREE       = 2'd3;
  localparam logic [PIX_W-1:0] PIX_MAX          = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_CPRD,
    ST_RD,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic write_px;
    logic adv_in;
    logic win_init;
    logic rd_win;
    logic acc;
    logic rd_copy;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_frame;
    logic is_filler;
    logic past_delay;
    logic filt;
    logic win_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

>>> sv/bfre_ctrl.sv
// ----------------------------------------------------------------------------
// bfre_ctrl
// Sequencer: takes one item, writes frame pixels, then copies or walks the
// window and divider when due, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bfre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bfre_pkg::sts_t sts_i,
  output bfre_pkg::cmd_t cmd_o
);
  import bfre_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        // filler inside the frame leaves everything untouched
        if (sts_i.in_frame && sts_i.is_filler) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.write_px = sts_i.in_frame;
          cmd_o.adv_in   = 1'b1;
          if (!sts_i.past_delay) begin
            state_d = ST_IDLE;
          end else if (sts_i.filt) begin
            cmd_o.win_init = 1'b1;
            state_d        = ST_RD;
          end else begin
            state_d = ST_CPRD;
          end
        end
      end
      ST_CPRD: begin
        cmd_o.rd_copy = 1'b1;
        state_d       = ST_OUT;
      end
      ST_RD: begin
        cmd_o.rd_win = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.win_last ? ST_DIV : ST_RD;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> sv/bfre_dp.sv
// ----------------------------------------------------------------------------
// bfre_dp
// Datapath: configuration registers, position counters, line store, window
// accumulators, restoring dividers and the output register.
// ----------------------------------------------------------------------------
module bfre_dp #(
  parameter int KERNEL_MAX = bfre_pkg::KERNEL_MAX_DEF,
  parameter int LINE_MAX   = bfre_pkg::LINE_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfre_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [bfre_pkg::PIX_W-1:0]     chan_a_i,
  input  logic [bfre_pkg::PIX_W-1:0]     chan_b_i,
  input  logic [bfre_pkg::PIX_W-1:0]     chan_c_i,
  input  logic                           filler_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bfre_pkg::PIX_W-1:0]     out_a_o,
  output logic [bfre_pkg::PIX_W-1:0]     out_b_o,
  output logic [bfre_pkg::PIX_W-1:0]     out_c_o,
  output logic                           end_of_frame_o,
  input  bfre_pkg::cmd_t                 cmd_i,
  output bfre_pkg::sts_t                 sts_o
);
  import bfre_pkg::*;

  localparam int KW     = $clog2(KERNEL_MAX + 1);
  localparam int RW     = $clog2((KERNEL_MAX > 1) ? KERNEL_MAX : 2);
  localparam int WW     = $clog2(KERNEL_MAX + 1);
  localparam int SUM_W  = $clog2(KERNEL_MAX * KERNEL_MAX * 255 + 1);
  localparam int DIV_W  = $clog2(KERNEL_MAX * KERNEL_MAX + 1);
  localparam int DC_W   = $clog2(SUM_W + 1);
  localparam int MEM_D  = KERNEL_MAX * LINE_MAX;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int LIN_W  = ROW_W + COL_W + 1;
  localparam int PX_W   = CH_N * PIX_W;

  // configuration
  logic [2:0]       k_q;
  logic [COL_W-1:0] fw_q, rx0_q, rx1_q, ry0_q, ry1_q;
  logic [H_W-1:0]   fh_q;
  logic [1:0]       cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= RST_KERNEL_SIZE;
      fw_q  <= RST_FRAME_WIDTH;
      fh_q  <= RST_FRAME_HEIGHT;
      rx0_q <= RST_ROI_FIRST;
      rx1_q <= RST_ROI_LAST;
      ry0_q <= RST_ROI_FIRST;
      ry1_q <= RST_ROI_LAST;
      cc_q  <= RST_CHAN_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KERNEL_SIZE:   k_q   <= cfg_data_i[2:0];
        REG_FRAME_WIDTH:   fw_q  <= cfg_data_i[COL_W-1:0];
        REG_FRAME_HEIGHT:  fh_q  <= cfg_data_i[H_W-1:0];
        REG_ROI_X_FIRST:   rx0_q <= cfg_data_i[COL_W-1:0];
        REG_ROI_X_LAST:    rx1_q <= cfg_data_i[COL_W-1:0];
        REG_ROI_Y_FIRST:   ry0_q <= cfg_data_i[COL_W-1:0];
        REG_ROI_Y_LAST:    ry1_q <= cfg_data_i[COL_W-1:0];
        REG_CHANNEL_COUNT: cc_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [KW-1:0]    k_eff, bnd;
  logic [DIV_W-1:0] div_v;
  logic [COL_W-1:0] w_eff;
  logic [H_W-1:0]   h_eff;
  logic             three;

  always_comb begin
    if (k_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_q) > KERNEL_MAX) begin
      k_eff = KW'(KERNEL_MAX);
    end else begin
      k_eff = KW'(k_q);
    end
    if (fw_q == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(fw_q) > LINE_MAX) begin
      w_eff = COL_W'(LINE_MAX);
    end else begin
      w_eff = fw_q;
    end
  end

  assign bnd   = KW'((k_eff - KW'(1)) >> 1);
  assign div_v = DIV_W'(DIV_W'(k_eff) * DIV_W'(k_eff));
  assign h_eff = (fh_q == '0) ? H_W'(1) : fh_q;
  assign three = (cc_q == CHAN_THREE);

  // position counters, row counters carry their line store slot alongside
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [RW-1:0]    in_rm_q, out_rm_q;
  logic             in_wrap, out_wrap, eof;

  // captured item and frame arithmetic
  logic [PIX_W-1:0] a_q, b_q, c_q;
  logic             fil_q;
  logic [LIN_W-1:0] prod_lin_q, area_q, prod_del_q;
  logic [LIN_W-1:0] lin, dly;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q   <= chan_a_i;
      b_q   <= chan_b_i;
      c_q   <= chan_c_i;
      fil_q <= filler_i;
    end
    if (cmd_i.mul) begin
      prod_lin_q <= LIN_W'(LIN_W'(in_row_q) * LIN_W'(w_eff));
      area_q     <= LIN_W'(LIN_W'(w_eff) * LIN_W'(h_eff));
      prod_del_q <= LIN_W'(LIN_W'(bnd) * LIN_W'(w_eff));
    end
  end

  assign lin = prod_lin_q + LIN_W'(in_col_q);
  assign dly = prod_del_q + LIN_W'(bnd);

  assign in_wrap  = (({1'b0, in_col_q} + (COL_W+1)'(1)) >= {1'b0, w_eff});
  assign out_wrap = (({1'b0, out_col_q} + (COL_W+1)'(1)) >= {1'b0, w_eff});
  assign eof      = out_wrap &&
                    (((ROW_W+1)'(out_row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff));

  function automatic logic [RW-1:0] rm_inc(input logic [RW-1:0] v);
    rm_inc = (32'(v) >= KERNEL_MAX - 1) ? '0 : RW'(v + RW'(1));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_rm_q   <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_rm_q  <= '0;
    end else begin
      if (cmd_i.adv_in) begin
        if (in_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + ROW_W'(1);
          in_rm_q  <= rm_inc(in_rm_q);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        if (eof) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_rm_q   <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          out_rm_q  <= '0;
        end else if (out_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
          out_rm_q  <= rm_inc(out_rm_q);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  // filter decision for the pixel at the output position
  logic filt;
  assign filt = (out_col_q >= rx0_q) && (out_col_q <= rx1_q) &&
                (out_row_q >= ROW_W'(ry0_q)) && (out_row_q <= ROW_W'(ry1_q)) &&
                (out_col_q >= COL_W'(bnd)) &&
                (({1'b0, out_col_q} + (COL_W+1)'(bnd)) < {1'b0, w_eff}) &&
                (out_row_q >= ROW_W'(bnd)) &&
                (((ROW_W+1)'(out_row_q) + (ROW_W+1)'(bnd)) < (ROW_W+1)'(h_eff));

  // window walk
  logic [WW-1:0]  win_r_q, win_c_q, span;
  logic [RW-1:0]  win_rm_q;
  logic [RW:0]    start_raw;
  logic [RW-1:0]  start_rm;
  logic [COL_W-1:0] win_col;

  assign span      = WW'({bnd, 1'b0});
  assign start_raw = (RW+1)'(out_rm_q) + (RW+1)'(KERNEL_MAX) - (RW+1)'(bnd);
  assign start_rm  = (32'(start_raw) >= KERNEL_MAX) ?
                     RW'(start_raw - (RW+1)'(KERNEL_MAX)) : RW'(start_raw);
  assign win_col   = out_col_q - COL_W'(bnd) + COL_W'(win_c_q);

  // line store
  logic [PX_W-1:0]   mem_q [MEM_D];
  logic [PX_W-1:0]   rd_data_q;
  logic              rd_zero_q;
  logic [COL_W-1:0]  rd_col;
  logic [RW-1:0]     rd_rm;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              rd_en;

  assign rd_en  = cmd_i.rd_win | cmd_i.rd_copy;
  assign rd_col = cmd_i.rd_copy ? out_col_q : win_col;
  assign rd_rm  = cmd_i.rd_copy ? out_rm_q : win_rm_q;
  assign waddr  = ADDR_W'(ADDR_W'(in_rm_q) * ADDR_W'(LINE_MAX) + ADDR_W'(in_col_q));
  assign raddr  = ADDR_W'(ADDR_W'(rd_rm) * ADDR_W'(LINE_MAX) + ADDR_W'(rd_col));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px && (32'(in_col_q) < LINE_MAX)) begin
      mem_q[waddr] <= {c_q, b_q, a_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[raddr];
      rd_zero_q <= (32'(rd_col) >= LINE_MAX);
    end
  end

  logic [PX_W-1:0] px;
  assign px = rd_zero_q ? '0 : rd_data_q;

  // per-channel accumulate then restoring divide in place
  logic [SUM_W-1:0] sum_q [CH_N];
  logic [DIV_W-1:0] rem_q [CH_N];
  logic [DC_W-1:0]  dcnt_q;
  logic [PIX_W-1:0] res [CH_N];

  for (genvar l = 0; l < CH_N; l++) begin : g_lane
    logic [DIV_W:0] r2;
    logic           ge;
    assign r2 = {rem_q[l], sum_q[l][SUM_W-1]};
    assign ge = (r2 >= (DIV_W+1)'(div_v));

    always_ff @(posedge clk_i) begin
      if (cmd_i.win_init) begin
        sum_q[l] <= '0;
        rem_q[l] <= '0;
      end else if (cmd_i.acc) begin
        sum_q[l] <= sum_q[l] + SUM_W'(px[l*PIX_W +: PIX_W]);
      end else if (cmd_i.div_step) begin
        rem_q[l] <= ge ? DIV_W'(r2 - (DIV_W+1)'(div_v)) : DIV_W'(r2);
        sum_q[l] <= {sum_q[l][SUM_W-2:0], ge};
      end
    end

    always_comb begin
      if (!filt) begin
        res[l] = px[l*PIX_W +: PIX_W];
      end else if (sum_q[l] > SUM_W'(PIX_MAX)) begin
        res[l] = PIX_MAX;
      end else begin
        res[l] = sum_q[l][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      win_r_q  <= '0;
      win_c_q  <= '0;
      win_rm_q <= start_rm;
      dcnt_q   <= '0;
    end else if (cmd_i.acc) begin
      if (win_c_q == span) begin
        win_c_q  <= '0;
        win_r_q  <= win_r_q + WW'(1);
        win_rm_q <= rm_inc(win_rm_q);
      end else begin
        win_c_q <= win_c_q + WW'(1);
      end
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DC_W'(1);
    end
  end

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] oa_q, ob_q, oc_q;
  logic             oe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      oa_q <= res[0];
      ob_q <= three ? res[1] : '0;
      oc_q <= three ? res[2] : '0;
      oe_q <= eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_a_o        = oa_q;
  assign out_b_o        = ob_q;
  assign out_c_o        = oc_q;
  assign end_of_frame_o = oe_q;

  assign sts_o.in_frame   = (lin < area_q);
  assign sts_o.is_filler  = fil_q;
  assign sts_o.past_delay = (lin >= dly);
  assign sts_o.filt       = filt;
  assign sts_o.win_last   = (win_c_q == span) && (win_r_q == span);
  assign sts_o.div_last   = (dcnt_q == DC_W'(SUM_W - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> sv/box_filter_roi_edge_copy.sv
// ----------------------------------------------------------------------------
// box_filter_roi_edge_copy
// Streaming box filter with region of interest and edge copy.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  chan_a_i chan_b_i chan_c_i filler_i
//   out       output     out_valid_o/out_ready_i out_a_o out_b_o out_c_o end_of_frame_o
//   cfg       input      cfg_we_i (no wait)     cfg_idx_i cfg_data_i
//
// one pixel at a time, set by the single line store port and the bit-serial divider:
// a copied pixel takes one line store read, a filtered one reads its (2b+1)^2 window
// pixels in turn (b = (k-1)/2) and divides over SUM_W bits (14 at KERNEL_MAX 7)
// a finished result waits in the output register while the next pixel is taken
// reset clears counters and control; line store content is not cleared
// ----------------------------------------------------------------------------
module box_filter_roi_edge_copy #(
  parameter int KERNEL_MAX = bfre_pkg::KERNEL_MAX_DEF,
  parameter int LINE_MAX   = bfre_pkg::LINE_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfre_pkg::PIX_W-1:0]      chan_a_i,
  input  logic [bfre_pkg::PIX_W-1:0]      chan_b_i,
  input  logic [bfre_pkg::PIX_W-1:0]      chan_c_i,
  input  logic                            filler_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bfre_pkg::PIX_W-1:0]      out_a_o,
  output logic [bfre_pkg::PIX_W-1:0]      out_b_o,
  output logic [bfre_pkg::PIX_W-1:0]      out_c_o,
  output logic                            end_of_frame_o,
  input  logic                            cfg_we_i,
  input  logic [bfre_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfre_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfre_dp #(
    .KERNEL_MAX (KERNEL_MAX),
    .LINE_MAX   (LINE_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .chan_a_i       (chan_a_i),
    .chan_b_i       (chan_b_i),
    .chan_c_i       (chan_c_i),
    .filler_i       (filler_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .out_c_o        (out_c_o),
    .end_of_frame_o (end_of_frame_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

>>> sv/bfre_checker.sv
// ----------------------------------------------------------------------------
// bfre_checker
// Port-level checks of the box filter, attached by bind.
// ----------------------------------------------------------------------------
module bfre_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [bfre_pkg::PIX_W-1:0]      out_a_o,
  input logic [bfre_pkg::PIX_W-1:0]      out_b_o,
  input logic [bfre_pkg::PIX_W-1:0]      out_c_o,
  input logic                            end_of_frame_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_a_o) &&
    $stable(out_b_o) && $stable(out_c_o) && $stable(end_of_frame_o))
    else $error("result changed while stalled");

  // one pixel in flight: no transfer in the cycle after a transfer
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back to back cycles");

  // a new result only appears after the block has been busy
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind box_filter_roi_edge_copy bfre_checker u_bfre_checker (.*);
